@@ rtl/icaf_pkg.sv @@
// shared types, register indexes and arithmetic helpers of the attitude filter
`timescale 1ns / 1ps
`default_nettype none

package icaf_pkg;

    // one sample set: three accelerometer axes and three gyro rates
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } icaf_in_t;

    // updated attitude, q16.16 degrees
    typedef struct packed {
        logic signed [31:0] pitch_deg;
        logic signed [31:0] roll_deg;
        logic signed [31:0] yaw_deg;
        logic               accel_blended;
    } icaf_out_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WEIGHT_W   = 17;
    localparam int SCALE_W    = 32;
    localparam int MAG_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_HIGH  = 2'd3;

    localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST    = 17'd64225;
    localparam logic [SCALE_W-1:0]  GYRO_STEP_SCALE_RST = 32'd2621;
    localparam logic [MAG_W-1:0]    MAGNITUDE_LOW_RST   = 17'd8192;
    localparam logic [MAG_W-1:0]    MAGNITUDE_HIGH_RST  = 17'd32768;
    localparam logic [WEIGHT_W-1:0] ONE_Q16             = 17'd65536;

    // angle slots
    localparam logic [1:0] AXIS_PITCH = 2'd0;
    localparam logic [1:0] AXIS_ROLL  = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    // multiplier operand selection
    localparam logic [1:0] MUL_GYRO  = 2'd0;
    localparam logic [1:0] MUL_ANGLE = 2'd1;
    localparam logic [1:0] MUL_ACC   = 2'd2;

    localparam int CORDIC_MAX_STEPS = 24;
    localparam int CORDIC_W         = 27;
    localparam int Z_W              = 27;
    localparam int ATAN_W           = 22;
    localparam int ATAN_IDX_W       = 5;
    localparam logic signed [Z_W-1:0] DEG180_Q16 = 27'sd11796480;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 51;
    localparam int WIDE_W  = 35;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       gyro_upd;
        logic       sum_load;
        logic       blend_upd;
        logic       cordic_start;
        logic       out_load;
        logic [1:0] axis;
    } icaf_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic blend;
    } icaf_status_t;

    // atan(2^-i) in q16.16 degrees
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] r;
        case (idx)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v[WIDE_W-1:31] != {(WIDE_W-31){v[WIDE_W-1]}}) begin
            r = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/imu_complementary_attitude_filter_unit.sv @@
// top level of the imu complementary attitude filter
`timescale 1ns / 1ps
`default_nettype none

// Complementary attitude filter. Each accepted transaction carries one set of
// signed accelerometer and gyro samples; the pitch, roll and yaw angles (q16.16
// degrees, saturating, kept from one transaction to the next) first take the gyro
// increment (subtracted for roll), and when the accelerometer absolute sum lies
// strictly inside the magnitude window each angle is blended with its cordic atan2
// angle. One result comes out per transaction. An item whose magnitude check fails
// skips the cordic; for a blended item the time is set by the single iterative
// cordic that runs once per axis and the one shared multiplier. A new item is taken
// as soon as the previous one sits in the output register. The user must write
// settings through cfg_wr_en / cfg_index / cfg_wr_data only while no transaction
// is in flight; the block does not enforce this.
module imu_complementary_attitude_filter_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire icaf_pkg::icaf_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output icaf_pkg::icaf_out_t                   m_data,
    input  wire logic                             cfg_wr_en,
    input  wire logic [icaf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [icaf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import icaf_pkg::*;

    icaf_cmd_t    cmd;
    icaf_status_t status;

    icaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    icaf_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_data)
    );

    // one item at a time: after a transaction the input stays closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // a result never overwrites one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten before transaction");

    // cordic runs only for items inside the magnitude window
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cordic_start |-> status.blend)
        else $error("cordic started for an item outside the window");

    // gyro and blend updates never hit the angles together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.gyro_upd && cmd.blend_upd))
        else $error("conflicting angle updates");

endmodule

`default_nettype wire

@@ rtl/icaf_cordic.sv @@
// iterative vectoring cordic, atan2 in q16.16 degrees
`timescale 1ns / 1ps
`default_nettype none

module icaf_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic signed [15:0]                 y_in,
    input  wire logic signed [15:0]                 x_in,
    output logic signed [icaf_pkg::Z_W-1:0]         z_out,
    output logic                                    done
);
    import icaf_pkg::*;

    localparam int STEPS_EFF = (STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : STEPS;
    localparam int CNT_W     = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS_EFF - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       zero_reg, zero_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]      z_reg, z_next;

    logic signed [16:0]         x_ext, y_ext, x_abs, y_adj;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]      atan_step;

    always_comb begin
        x_ext = {x_in[15], x_in};
        y_ext = {y_in[15], y_in};
        x_abs = x_in[15] ? -x_ext : x_ext;
        y_adj = x_in[15] ? -y_ext : y_ext;
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        atan_step = {{(Z_W-ATAN_W){1'b0}}, atan_lut(ATAN_IDX_W'(cnt_reg))};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            zero_next = (x_in == 16'sd0) && (y_in == 16'sd0);
            // left half plane: rotate by 180 degrees first
            x_next = {{(CORDIC_W-25){x_abs[16]}}, x_abs, 8'h00};
            y_next = {{(CORDIC_W-25){y_adj[16]}}, y_adj, 8'h00};
            if (x_in[15]) begin
                z_next = y_in[15] ? -DEG180_Q16 : DEG180_Q16;
            end else begin
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_step;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_step;
            end
            if (cnt_reg == LAST_CNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign z_out = zero_reg ? '0 : z_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

@@ rtl/icaf_datapath.sv @@
// attitude registers, settings, shared multiplier and cordic of the filter
`timescale 1ns / 1ps
`default_nettype none

module icaf_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire icaf_pkg::icaf_in_t                  s_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [icaf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [icaf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire icaf_pkg::icaf_cmd_t                 cmd,
    output icaf_pkg::icaf_status_t                   status,
    output icaf_pkg::icaf_out_t                      out_data
);
    import icaf_pkg::*;

    logic [WEIGHT_W-1:0] blend_weight_reg;
    logic [SCALE_W-1:0]  gyro_step_scale_reg;
    logic [MAG_W-1:0]    magnitude_low_reg;
    logic [MAG_W-1:0]    magnitude_high_reg;

    icaf_in_t            in_reg;
    logic                blend_reg;
    logic signed [31:0]  angle_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] sum_reg;
    icaf_out_t           out_reg;

    logic [MAG_W-1:0]         mag;
    logic                     in_window;
    logic [WEIGHT_W-1:0]      w_eff, w_comp;
    logic signed [15:0]       gyro_sel;
    logic signed [31:0]       angle_cur;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [WIDE_W-1:0] angle_wide, gyro_inc, gyro_sum, blend_q;
    logic signed [PROD_W-1:0] blend_total;
    logic signed [15:0]       cordic_y, cordic_x;
    logic signed [Z_W-1:0]    acc_angle;
    logic                     cordic_done;

    function automatic logic [MAG_W-1:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? MAG_W'(-e) : MAG_W'(e);
    endfunction

    // settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_weight_reg    <= BLEND_WEIGHT_RST;
            gyro_step_scale_reg <= GYRO_STEP_SCALE_RST;
            magnitude_low_reg   <= MAGNITUDE_LOW_RST;
            magnitude_high_reg  <= MAGNITUDE_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BLEND_WEIGHT:    blend_weight_reg    <= cfg_wr_data[WEIGHT_W-1:0];
                CFG_GYRO_STEP_SCALE: gyro_step_scale_reg <= cfg_wr_data[SCALE_W-1:0];
                CFG_MAGNITUDE_LOW:   magnitude_low_reg   <= cfg_wr_data[MAG_W-1:0];
                CFG_MAGNITUDE_HIGH:  magnitude_high_reg  <= cfg_wr_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mag = abs16(s_data.accel_x) + abs16(s_data.accel_y) + abs16(s_data.accel_z);
        in_window = (mag > magnitude_low_reg) && (mag < magnitude_high_reg);
        w_eff  = (blend_weight_reg > ONE_Q16) ? ONE_Q16 : blend_weight_reg;
        w_comp = ONE_Q16 - w_eff;
        angle_cur = angle_reg[cmd.axis];
        angle_wide = {{(WIDE_W-32){angle_cur[31]}}, angle_cur};
    end

    always_comb begin
        case (cmd.axis)
            AXIS_ROLL: begin
                gyro_sel = in_reg.gyro_y;
                cordic_y = in_reg.accel_x;
                cordic_x = in_reg.accel_z;
            end
            AXIS_YAW: begin
                gyro_sel = in_reg.gyro_z;
                cordic_y = in_reg.accel_x;
                cordic_x = in_reg.accel_y;
            end
            default: begin
                gyro_sel = in_reg.gyro_x;
                cordic_y = in_reg.accel_y;
                cordic_x = in_reg.accel_z;
            end
        endcase
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_GYRO: begin
                mul_a = {1'b0, gyro_step_scale_reg};
                mul_b = {{(MUL_B_W-16){gyro_sel[15]}}, gyro_sel};
            end
            MUL_ANGLE: begin
                mul_a = {{(MUL_A_W-32){angle_cur[31]}}, angle_cur};
                mul_b = {1'b0, w_eff};
            end
            MUL_ACC: begin
                mul_a = {{(MUL_A_W-Z_W){acc_angle[Z_W-1]}}, acc_angle};
                mul_b = {1'b0, w_comp};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // floor shifts by 16 are plain arithmetic part-selects
    always_comb begin
        gyro_inc = prod_reg[PROD_W-1:16];
        gyro_sum = (cmd.axis == AXIS_ROLL) ? angle_wide - gyro_inc : angle_wide + gyro_inc;
        blend_total = sum_reg + prod_reg;
        blend_q = blend_total[PROD_W-1:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg[0] <= '0;
            angle_reg[1] <= '0;
            angle_reg[2] <= '0;
        end else if (cmd.gyro_upd) begin
            angle_reg[cmd.axis] <= sat32(gyro_sum);
        end else if (cmd.blend_upd) begin
            angle_reg[cmd.axis] <= sat32(blend_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg    <= s_data;
            blend_reg <= in_window;
        end
        if (cmd.mul_en) begin
            prod_reg <= product;
        end
        if (cmd.sum_load) begin
            sum_reg <= prod_reg;
        end
        if (cmd.out_load) begin
            out_reg.pitch_deg     <= angle_reg[0];
            out_reg.roll_deg      <= angle_reg[1];
            out_reg.yaw_deg       <= angle_reg[2];
            out_reg.accel_blended <= blend_reg;
        end
    end

    icaf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cordic_start),
        .y_in    (cordic_y),
        .x_in    (cordic_x),
        .z_out   (acc_angle),
        .done    (cordic_done)
    );

    assign status.cordic_done = cordic_done;
    assign status.blend       = blend_reg;
    assign out_data           = out_reg;

endmodule

`default_nettype wire

@@ rtl/icaf_ctrl.sv @@
// sequencer of the attitude filter: handshakes and datapath commands
`timescale 1ns / 1ps
`default_nettype none

module icaf_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    input  wire icaf_pkg::icaf_status_t  status,
    output icaf_pkg::icaf_cmd_t          cmd
);
    import icaf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GMUL   = 4'd1;
    localparam logic [3:0] S_GACC   = 4'd2;
    localparam logic [3:0] S_CSTART = 4'd3;
    localparam logic [3:0] S_CRUN   = 4'd4;
    localparam logic [3:0] S_BMUL0  = 4'd5;
    localparam logic [3:0] S_BMUL1  = 4'd6;
    localparam logic [3:0] S_BADD   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.axis     = axis_reg;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_PITCH;
                    state_next = S_GMUL;
                end
            end
            S_GMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GYRO;
                state_next  = S_GACC;
            end
            S_GACC: begin
                cmd.gyro_upd = 1'b1;
                if (axis_reg == AXIS_YAW) begin
                    axis_next  = AXIS_PITCH;
                    state_next = status.blend ? S_CSTART : S_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_GMUL;
                end
            end
            S_CSTART: begin
                cmd.cordic_start = 1'b1;
                state_next       = S_CRUN;
            end
            S_CRUN: begin
                if (status.cordic_done) begin
                    state_next = S_BMUL0;
                end
            end
            S_BMUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ANGLE;
                state_next  = S_BMUL1;
            end
            S_BMUL1: begin
                // gyro-weighted product moves to the sum while the accel term is formed
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_ACC;
                cmd.sum_load = 1'b1;
                state_next   = S_BADD;
            end
            S_BADD: begin
                cmd.blend_upd = 1'b1;
                if (axis_reg == AXIS_YAW) begin
                    state_next = S_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_CSTART;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= AXIS_PITCH;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
